// File: rtl/tachwa_pkg.sv
// shared types and constants of the tachometer window average unit
package tachwa_pkg;

  localparam int unsigned PeriodW = 32;
  localparam int unsigned ClkHzW  = 32;
  localparam int unsigned IntvW   = 8;
  localparam int unsigned DvdW    = 48;
  localparam int unsigned DvsW    = 32;
  localparam int unsigned FreqW   = 48;
  localparam int unsigned AngW    = 51;
  localparam int unsigned FracW   = 16;
  localparam int unsigned MulBW   = 19;
  localparam int unsigned DivCntW = 6;

  // round(2*pi*65536)
  localparam logic [MulBW-1:0]   TWO_PI_Q16 = 19'd411775;
  localparam logic [DivCntW-1:0] DIV_LAST   = 6'd47;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_ENOUGH = 2'd1,
    STATUS_ZERO       = 2'd2
  } status_e;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic {
    CFG_CLOCK_HZ        = 1'b0,
    CFG_REPORT_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_AVG,
    ST_WAIT_AVG,
    ST_DIV_FREQ,
    ST_WAIT_FREQ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/tachwa_div.sv
// restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor
module tachwa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tachwa_pkg::DvdW-1:0]    dividend_i,
  input  logic [tachwa_pkg::DvsW-1:0]    divisor_i,
  output tachwa_pkg::div_stat_t          stat_o,
  output logic [tachwa_pkg::DvdW-1:0]    quotient_o
);
  import tachwa_pkg::*;

  logic [DvdW-1:0]    quo_q;
  logic [DvsW-1:0]    rem_q;
  logic [DvsW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DvsW:0]      rem_sh;
  logic [DvsW:0]      rem_sub;
  logic               ge;
  logic [DvsW-1:0]    rem_next;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    rem_sh   = {rem_q, quo_q[DvdW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_q};
    ge       = (rem_sh >= {1'b0, dvs_q});
    rem_next = ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// File: rtl/tachometer_window_average_unit.sv
// top level of the period capture tachometer with moving-average window
//
// input channel: one beat is a capture event (operation 0, raw down-counter
// value) or a report tick (operation 1). in_stall_o is low only while the
// sequencer is idle. a capture or a non-reporting tick leaves the sequencer idle.
// a reporting tick with a full window sums the window, then runs the shared
// one-bit-per-cycle divider twice (window sum by WINDOW_SIZE, then clock_hz
// in Q16 by the average) and the shared 32x19 multiplier twice; its result
// beat becomes valid in the same cycle that input reopens.
// a zero average skips the second division and the multiplies.
// a reporting tick with a window not yet full goes straight to the done
// state, which loads a not-enough beat into the output register.
// output channel: a registered result beat; while out_stall_i holds it, the
// next finished report waits in the sequencer, and input keeps stalling.
// config channel: cfg_ready_o is always high; write only while idle.
// reset (asynchronous, active low) clears the window pointer, fill count,
// tick count and output valid, and loads clock_hz = 50000000 and
// report_interval = 10. window entries are not cleared.
module tachometer_window_average_unit #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [tachwa_pkg::PeriodW-1:0]      capture_value_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [tachwa_pkg::PeriodW-1:0]      avg_period_o,
  output logic [tachwa_pkg::FreqW-1:0]        frequency_q16_o,
  output logic [tachwa_pkg::AngW-1:0]         angular_velocity_q16_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [tachwa_pkg::ClkHzW-1:0]       cfg_data_i
);
  import tachwa_pkg::*;

  localparam int unsigned IdxW  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FillW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SumW  = PeriodW + $clog2(WINDOW_SIZE);
  localparam int unsigned ProdW = PeriodW + MulBW;

  // configuration registers
  logic [ClkHzW-1:0] clock_hz_q;
  logic [IntvW-1:0]  intv_q;

  // control state
  state_e            state_q, state_d;
  logic [IdxW-1:0]   wp_q;
  logic [FillW-1:0]  fill_q;
  logic [IntvW-1:0]  tick_q;
  logic [FillW-1:0]  cnt_q;

  // window store and datapath
  logic [PeriodW-1:0] win_q [WINDOW_SIZE];
  logic [PeriodW-1:0] rd_q;
  logic [SumW-1:0]    sum_q;
  logic [PeriodW-1:0] avg_q;
  logic [FreqW-1:0]   freq_q;
  logic [MulBW-1:0]   acc_q;
  logic [AngW-1:0]    ang_q;
  status_e            res_status_q;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [PeriodW-1:0] out_avg_q;
  logic [FreqW-1:0]   out_freq_q;
  logic [AngW-1:0]    out_ang_q;

  // handshake decode
  logic               in_fire;
  logic               is_capture;
  logic               is_tick;
  logic [IntvW-1:0]   tick_next;
  logic               report;
  logic               win_full;
  logic               slot_free;

  // shared units
  logic               div_start;
  logic [DvdW-1:0]    div_dividend;
  logic [DvsW-1:0]    div_divisor;
  div_stat_t          div_stat;
  logic [DvdW-1:0]    div_quo;
  logic [PeriodW-1:0] mul_a;
  logic [ProdW-1:0]   mul_p;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign is_capture  = in_fire && (op_e'(operation_i) == OP_CAPTURE);
  assign is_tick     = in_fire && (op_e'(operation_i) == OP_TICK);
  assign tick_next   = tick_q + 1'b1;
  assign report      = (tick_next >= intv_q);
  assign win_full    = (fill_q == FillW'(WINDOW_SIZE));
  assign slot_free   = !out_valid_q || !out_stall_i;

  tachwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // one 32x19 multiplier, used for the low then the high frequency half
  assign mul_p = ProdW'(mul_a) * ProdW'(TWO_PI_Q16);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_tick && report) begin
          state_d = win_full ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        if (cnt_q == FillW'(WINDOW_SIZE)) begin
          state_d = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG:  state_d = ST_WAIT_AVG;
      ST_WAIT_AVG: begin
        if (div_stat.done) begin
          // zero average skips the frequency path and saturates
          state_d = (div_quo[PeriodW-1:0] == '0) ? ST_DONE : ST_DIV_FREQ;
        end
      end
      ST_DIV_FREQ:  state_d = ST_WAIT_FREQ;
      ST_WAIT_FREQ: begin
        if (div_stat.done) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {clock_hz_q, {FracW{1'b0}}};
    div_divisor  = avg_q;
    mul_a        = {{(PeriodW - FracW){1'b0}}, freq_q[FracW-1:0]};
    unique case (state_q)
      ST_DIV_AVG: begin
        div_start    = 1'b1;
        div_dividend = DvdW'(sum_q);
        div_divisor  = DvsW'(WINDOW_SIZE);
      end
      ST_DIV_FREQ: div_start = 1'b1;
      ST_MUL_HI:   mul_a     = freq_q[FreqW-1:FracW];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= 32'd50000000;
      intv_q     <= 8'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLOCK_HZ:        clock_hz_q <= cfg_data_i;
        CFG_REPORT_INTERVAL: intv_q     <= cfg_data_i[IntvW-1:0];
        default: ;
      endcase
    end
  end

  // window pointer, fill count, tick count, sum counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      tick_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (is_capture) begin
        wp_q <= (wp_q == IdxW'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
        if (!win_full) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (is_tick) begin
        tick_q <= report ? '0 : tick_next;
      end
      if (state_q == ST_SUM) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // window store: period is all ones minus the captured down-count
  always_ff @(posedge clk_i) begin
    if (is_capture) begin
      win_q[wp_q] <= ~capture_value_i;
    end
    if (state_q == ST_SUM && cnt_q != FillW'(WINDOW_SIZE)) begin
      rd_q <= win_q[cnt_q[IdxW-1:0]];
    end
  end

  // report datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        sum_q        <= '0;
        res_status_q <= STATUS_NOT_ENOUGH;
        avg_q        <= '0;
        freq_q       <= '0;
        ang_q        <= '0;
      end
      ST_SUM: begin
        // read data comes from a registered read, so it trails the address
        if (cnt_q != '0) begin
          sum_q <= sum_q + SumW'(rd_q);
        end
      end
      ST_WAIT_AVG: begin
        if (div_stat.done) begin
          avg_q <= div_quo[PeriodW-1:0];
          if (div_quo[PeriodW-1:0] == '0) begin
            res_status_q <= STATUS_ZERO;
            freq_q       <= '1;
            ang_q        <= '1;
          end
        end
      end
      ST_WAIT_FREQ: begin
        if (div_stat.done) begin
          freq_q <= div_quo;
        end
      end
      ST_MUL_LO: acc_q <= mul_p[FracW+MulBW-1:FracW];
      ST_MUL_HI: begin
        ang_q        <= AngW'(mul_p) + AngW'(acc_q);
        res_status_q <= STATUS_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && slot_free) begin
      out_status_q <= res_status_q;
      out_avg_q    <= avg_q;
      out_freq_q   <= freq_q;
      out_ang_q    <= ang_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = out_status_q;
  assign avg_period_o           = out_avg_q;
  assign frequency_q16_o        = out_freq_q;
  assign angular_velocity_q16_o = out_ang_q;

`ifndef NO_ASSERTIONS
  // fill count saturates at the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW_SIZE))
    else $error("fill count beyond window depth");

  // the divider is never restarted while it runs
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a divider result only shows up where the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_WAIT_AVG || state_q == ST_WAIT_FREQ))
    else $error("divider result with nobody waiting");

  // a finished report holds while the output slot is occupied
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> state_q == ST_DONE)
    else $error("report dropped while output stalled");

  // a report is only started from a full window
  a_sum_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> win_full)
    else $error("window summed before full");
`endif

endmodule

// File: dv/tb.sv
// testbench for the tachometer window average unit, checked against a local predictor
`timescale 1ns / 1ps

module tb;
  import tachwa_pkg::*;

  // window depth of the unit under test
  localparam int unsigned WIN = 5;
  // settle time after the last owed report, enough to cover a whole report
  localparam int unsigned SETTLE_CYCLES = 160;
  // cycles without any accepted beat before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // receiver hold-off used to fill the unit and stall its input
  localparam int unsigned HOLD_CYCLES = 400;
  // round(2*pi*65536)
  localparam logic [63:0] TWO_PI_FIX = 64'd411775;
  localparam logic [47:0] FREQ_ALL_ONES = {48{1'b1}};
  localparam logic [50:0] ANG_ALL_ONES = {51{1'b1}};
  // only the first mismatches are printed, every one is counted
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    status_e      status;
    logic [31:0]  avg_period;
    logic [47:0]  frequency;
    logic [50:0]  angular;
  } report_t;

  // clock, reset and ports of the unit
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i = 1'b0;
  logic [PeriodW-1:0]   capture_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [PeriodW-1:0]   avg_period_o;
  logic [FreqW-1:0]     frequency_q16_o;
  logic [AngW-1:0]      angular_velocity_q16_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [ClkHzW-1:0]    cfg_data_i = '0;

  // predictor state: the period window, its pointer and fill level, the tick counter
  logic [31:0]  period_win [WIN];
  int unsigned  win_ptr = 0;
  int unsigned  win_fill = 0;
  logic [7:0]   tick_cnt = '0;
  // predictor copy of the two registers, at their reset values
  logic [31:0]  clock_hz_reg = 32'd50000000;
  logic [7:0]   interval_reg = 8'd10;

  // reports that the unit still owes, oldest first
  report_t      pending_reports [$];

  // idle chances in percent per cycle, changed by the tests
  int unsigned  tx_idle_pct = 21;
  int unsigned  rx_idle_pct = 21;
  int unsigned  rx_hold_req = 0;
  int unsigned  rx_hold_left = 0;

  // bookkeeping
  int unsigned  mismatches = 0;
  int unsigned  captures_sent = 0;
  int unsigned  ticks_sent = 0;
  int unsigned  reg_writes = 0;
  int unsigned  ok_reports = 0;
  int unsigned  short_reports = 0;
  int unsigned  zero_reports = 0;
  int unsigned  quiet_cycles = 0;

  tachometer_window_average_unit #(
    .WINDOW_SIZE(WIN)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .capture_value_i       (capture_value_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .avg_period_o          (avg_period_o),
    .frequency_q16_o       (frequency_q16_o),
    .angular_velocity_q16_o(angular_velocity_q16_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // average over the window, frequency in Q32.16 and angular velocity in Q35.16
  function automatic report_t compute_report();
    logic [34:0]  sum;
    logic [63:0]  avg;
    logic [63:0]  freq;
    logic [63:0]  whole;
    logic [63:0]  frac;
    logic [63:0]  ang;
    report_t      r;
    // window still filling: nothing to average yet
    if (win_fill < WIN) begin
      r.status = STATUS_NOT_ENOUGH;
      r.avg_period = '0;
      r.frequency = '0;
      r.angular = '0;
      return r;
    end
    sum = '0;
    for (int i = 0; i < WIN; i++) sum += period_win[i];
    avg = sum / WIN;
    // zero average: flag it and saturate both rates
    if (avg == 0) begin
      r.status = STATUS_ZERO;
      r.avg_period = '0;
      r.frequency = FREQ_ALL_ONES;
      r.angular = ANG_ALL_ONES;
      return r;
    end
    freq = ({32'd0, clock_hz_reg} << 16) / avg;
    if (freq > {16'd0, FREQ_ALL_ONES}) freq = {16'd0, FREQ_ALL_ONES};
    // integer and fraction parts are scaled separately so nothing overflows
    whole = freq >> 16;
    frac = freq & 64'hFFFF;
    ang = whole * TWO_PI_FIX + ((frac * TWO_PI_FIX) >> 16);
    if (ang > {13'd0, ANG_ALL_ONES}) ang = {13'd0, ANG_ALL_ONES};
    r.status = STATUS_OK;
    r.avg_period = avg[31:0];
    r.frequency = freq[47:0];
    r.angular = ang[50:0];
    return r;
  endfunction

  // one accepted event: a capture fills the window, a reporting tick owes a report
  task automatic advance_tachometer(input op_e op, input logic [31:0] raw);
    if (op == OP_CAPTURE) begin
      period_win[win_ptr] = 32'hFFFF_FFFF - raw;
      win_ptr = (win_ptr + 1) % WIN;
      if (win_fill < WIN) win_fill++;
      captures_sent++;
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      ticks_sent++;
      // an interval of zero reports on every tick
      if (tick_cnt >= interval_reg) begin
        tick_cnt = '0;
        pending_reports.push_back(compute_report());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // offer one event beat, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_event(input op_e op, input logic [31:0] raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      // idle cycle with junk on the payload lines
      in_valid_i <= 1'b0;
      operation_i <= $urandom_range(1);
      capture_value_i <= $urandom;
      @(posedge clk_i);
    end
    // valid stays high after acceptance so a back-to-back beat needs no toggle
    in_valid_i <= 1'b1;
    operation_i <= op;
    capture_value_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    advance_tachometer(op, raw);
  endtask

  // stop offering, wait for every owed report, then let the sequencer settle
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write beat; only called while the unit is idle
  task automatic write_register(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CLOCK_HZ) clock_hz_reg = data;
    else interval_reg = data[7:0];
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random event with values biased toward tiny periods and both extremes
  task automatic send_random_event(input int unsigned tick_pct);
    op_e          op;
    logic [31:0]  raw;
    op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_CAPTURE;
    case ($urandom_range(9))
      0: raw = 32'hFFFF_FFFF;
      1: raw = 32'h0000_0000;
      2, 3: raw = 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: raw = $urandom;
    endcase
    send_event(op, raw);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall, or a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted beat against the oldest owed report
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result beat with none owed, status %0d", status_o));
      end else begin
        want = pending_reports.pop_front();
        case (want.status)
          STATUS_OK: ok_reports++;
          STATUS_NOT_ENOUGH: short_reports++;
          default: zero_reports++;
        endcase
        if (status_o != want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (avg_period_o != want.avg_period)
          report_mismatch($sformatf("avg_period %0d, want %0d",
                                    avg_period_o, want.avg_period));
        if (frequency_q16_o != want.frequency)
          report_mismatch($sformatf("frequency_q16 %0h, want %0h",
                                    frequency_q16_o, want.frequency));
        if (angular_velocity_q16_o != want.angular)
          report_mismatch($sformatf("angular_velocity_q16 %0h, want %0h",
                                    angular_velocity_q16_o, want.angular));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles in which no beat moves on any channel
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d reports owed",
               quiet_cycles, pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: interval 10 gives a short-window report, clock 50 MHz a full one
  task automatic test_defaults_and_short_window();
    for (int i = 0; i < 4; i++) send_event(OP_CAPTURE, $urandom);
    for (int i = 0; i < 10; i++) send_event(OP_TICK, $urandom);
    wait_until_idle();
    write_register(CFG_REPORT_INTERVAL, 32'd1);
    // raw value zero is the longest possible period
    send_event(OP_CAPTURE, 32'h0000_0000);
    send_event(OP_TICK, $urandom);
  endtask

  // all periods zero with the largest clock: zero average, saturated rates
  task automatic test_zero_average();
    wait_until_idle();
    write_register(CFG_CLOCK_HZ, 32'hFFFF_FFFF);
    for (int i = 0; i < WIN; i++) send_event(OP_CAPTURE, 32'hFFFF_FFFF);
    send_event(OP_TICK, $urandom);
  endtask

  // zero clock gives zero rates, a zero interval reports on every tick
  task automatic test_zero_clock_and_interval();
    wait_until_idle();
    write_register(CFG_CLOCK_HZ, 32'd0);
    write_register(CFG_REPORT_INTERVAL, 32'd0);
    send_event(OP_CAPTURE, 32'h0000_0000);
    send_event(OP_TICK, $urandom);
    send_event(OP_TICK, $urandom);
  endtask

  // receiver holds off while the sender keeps offering: the unit fills and stalls input
  task automatic test_output_backpressure();
    wait_until_idle();
    write_register(CFG_CLOCK_HZ, $urandom);
    write_register(CFG_REPORT_INTERVAL, 32'd1);
    tx_idle_pct = 0;
    rx_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_random_event(80);
    tx_idle_pct = 21;
    // sender pauses until every owed report is back
    wait_until_idle();
  endtask

  // phases of random events, each under its own register setting
  task automatic test_random_phases();
    logic [31:0]  clk_val;
    logic [31:0]  intv_val;
    int unsigned  n_items;
    int unsigned  tick_pct;
    for (int phase = 0; phase < 9; phase++) begin
      wait_until_idle();
      case ($urandom_range(3))
        0: clk_val = 32'd1;
        1: clk_val = 32'hFFFF_FFFF;
        2: clk_val = 32'd50000000;
        default: clk_val = $urandom;
      endcase
      intv_val = $urandom_range(2, 6);
      n_items = 32;
      tick_pct = $urandom_range(30, 70);
      // first phase at the bottom of both ranges
      if (phase == 0) begin
        clk_val = 32'd1;
        intv_val = 32'd1;
      end
      if (phase == 1) clk_val = 32'hFFFF_FFFF;
      // top of the interval range: a long run of ticks is sure to reach it
      if (phase == 5) begin
        intv_val = 32'd255;
        n_items = 280;
        tick_pct = 100;
      end
      write_register(CFG_CLOCK_HZ, clk_val);
      write_register(CFG_REPORT_INTERVAL, intv_val);
      // one phase with no idling on either side
      if (phase == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 21;
        rx_idle_pct = 21;
      end
      for (int i = 0; i < n_items; i++) send_random_event(tick_pct);
    end
    tx_idle_pct = 21;
    rx_idle_pct = 21;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_short_window();
    test_zero_average();
    test_zero_clock_and_interval();
    test_output_backpressure();
    test_random_phases();

    wait_until_idle();
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    $display("run covered %0d captures, %0d ticks and %0d register writes",
             captures_sent, ticks_sent, reg_writes);
    $display("reports checked: %0d ok, %0d short window, %0d zero average; %0d mismatches",
             ok_reports, short_reports, zero_reports, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
